FILE: rtl/fcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcp_pkg
// Shared types, constants and helpers for the fixed-column element card
// parser: beat formats, field phase, kind codes and the type-name decoder.
// ----------------------------------------------------------------------------
package fcp_pkg;

	localparam int COLUMN_LIMIT = 127;
	localparam int COL_W        = $clog2(COLUMN_LIMIT + 1);
	localparam int KIND_CHARS   = 6;
	localparam int NUM_FIELDS   = 5;
	localparam int VAL_W        = 28;
	localparam int ACC_W        = VAL_W - 1;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// index 0 holds column 0
	localparam logic [5:0][7:0] NAME_TRI  = {"3", "A", "I", "R", "T", "C"};
	localparam logic [5:0][7:0] NAME_QUAD = {"4", "D", "A", "U", "Q", "C"};
	localparam logic [4:0][7:0] NAME_BEAM = {"M", "A", "E", "B", "C"};

	localparam logic ST_OK      = 1'b0;
	localparam logic ST_UNKNOWN = 1'b1;

	typedef enum logic [1:0] {
		KIND_TRI  = 2'd0,
		KIND_QUAD = 2'd1,
		KIND_BEAM = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_SKIP = 2'd0,
		PH_NUM  = 2'd1,
		PH_STOP = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       line_end;
	} char_beat_t;

	typedef struct packed {
		logic                    status;
		logic [1:0]              elem_kind;
		logic signed [VAL_W-1:0] elem_id;
		logic signed [VAL_W-1:0] node_a;
		logic signed [VAL_W-1:0] node_b;
		logic signed [VAL_W-1:0] node_c;
		logic signed [VAL_W-1:0] node_d;
	} card_beat_t;

	// final line contents handed from the scanner to the result stage
	typedef struct packed {
		logic [KIND_CHARS-1:0][7:0]  kind_chars;
		logic [NUM_FIELDS-1:0][VAL_W-1:0] fields;
	} line_t;

	typedef struct packed {
		logic  ok;
		kind_t kind;
	} kind_dec_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// trimmed compare: six-char names fill all slots, the five-char name
	// sits either left or right with one blank slot beside it
	function automatic kind_dec_t decode_kind(input logic [KIND_CHARS-1:0][7:0] k);
		kind_dec_t d;
		d.ok   = 1'b1;
		d.kind = KIND_TRI;
		if (k == NAME_TRI) begin
			d.kind = KIND_TRI;
		end else if (k == NAME_QUAD) begin
			d.kind = KIND_QUAD;
		end else if ((k[4:0] == NAME_BEAM && is_ws(k[5])) ||
		             (k[5:1] == NAME_BEAM && is_ws(k[0]))) begin
			d.kind = KIND_BEAM;
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

endpackage

FILE: rtl/fcp_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcp_scan
// Per-character line state: column count, type-name characters, the atoi
// accumulator and the five converted fields. Presents the finished line
// contents combinationally on the beat that ends the line.
// ----------------------------------------------------------------------------
module fcp_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  fcp_pkg::char_beat_t beat,
	output fcp_pkg::line_t      fin
);

	logic [fcp_pkg::COL_W-1:0]                               col_q;
	logic [fcp_pkg::KIND_CHARS-1:0][7:0]                     kind_q;
	logic [fcp_pkg::ACC_W-1:0]                               acc_q;
	logic                                                    neg_q;
	fcp_pkg::phase_t                                         phase_q;
	logic [fcp_pkg::NUM_FIELDS-1:0][fcp_pkg::VAL_W-1:0]      fv_q;

	logic                                                    in_id, in_node, in_field;
	logic [fcp_pkg::COL_W-1:0]                               node_off;
	logic [2:0]                                              slot;
	logic                                                    fld_start;
	logic [fcp_pkg::ACC_W-1:0]                               acc_b, acc_n;
	logic                                                    neg_b, neg_n;
	fcp_pkg::phase_t                                         ph_b, ph_n;
	logic                                                    take_num, is_digit;
	logic [fcp_pkg::VAL_W-1:0]                               res;
	logic [fcp_pkg::KIND_CHARS-1:0][7:0]                     kind_n;
	logic [fcp_pkg::NUM_FIELDS-1:0][fcp_pkg::VAL_W-1:0]      fv_n;

	assign in_id    = col_q >= fcp_pkg::COL_W'(8) && col_q <= fcp_pkg::COL_W'(15);
	assign in_node  = col_q >= fcp_pkg::COL_W'(24) && col_q <= fcp_pkg::COL_W'(55);
	assign in_field = in_id || in_node;
	assign node_off = col_q - fcp_pkg::COL_W'(24);
	assign slot     = in_id ? 3'd0 : 3'(node_off >> 3) + 3'd1;
	assign fld_start = col_q[2:0] == 3'd0;
	assign is_digit = beat.char_code >= fcp_pkg::CH_ZERO &&
	                  beat.char_code <= fcp_pkg::CH_NINE;

	always_comb begin
		acc_b = fld_start ? '0 : acc_q;
		neg_b = fld_start ? 1'b0 : neg_q;
		ph_b  = fld_start ? fcp_pkg::PH_SKIP : phase_q;
		acc_n = acc_b;
		neg_n = neg_b;
		ph_n  = ph_b;
		take_num = 1'b0;
		if (ph_b == fcp_pkg::PH_SKIP) begin
			if (!fcp_pkg::is_ws(beat.char_code)) begin
				ph_n = fcp_pkg::PH_NUM;
				if (beat.char_code == fcp_pkg::CH_MINUS) begin
					neg_n = 1'b1;
				end else if (beat.char_code != fcp_pkg::CH_PLUS) begin
					take_num = 1'b1;
				end
			end
		end else if (ph_b == fcp_pkg::PH_NUM) begin
			take_num = 1'b1;
		end
		if (take_num) begin
			if (is_digit) begin
				// acc*10 + digit, wraps at accumulator width
				acc_n = fcp_pkg::ACC_W'({acc_b, 3'b000}) +
				        fcp_pkg::ACC_W'({acc_b, 1'b0}) +
				        fcp_pkg::ACC_W'(beat.char_code[3:0]);
			end else begin
				ph_n = fcp_pkg::PH_STOP;
			end
		end
		res = neg_n ? (fcp_pkg::VAL_W'(0) - {1'b0, acc_n}) : {1'b0, acc_n};

		kind_n = kind_q;
		if (col_q < fcp_pkg::COL_W'(fcp_pkg::KIND_CHARS))
			kind_n[col_q[2:0]] = beat.char_code;

		fv_n = fv_q;
		if (in_field && (col_q[2:0] == 3'd7 || beat.line_end))
			fv_n[slot] = res;

		fin.kind_chars = kind_n;
		fin.fields     = fv_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			kind_q  <= {fcp_pkg::KIND_CHARS{fcp_pkg::CH_SPACE}};
			acc_q   <= '0;
			neg_q   <= 1'b0;
			phase_q <= fcp_pkg::PH_SKIP;
			fv_q    <= '0;
		end else if (adv) begin
			if (beat.line_end) begin
				col_q   <= '0;
				kind_q  <= {fcp_pkg::KIND_CHARS{fcp_pkg::CH_SPACE}};
				acc_q   <= '0;
				neg_q   <= 1'b0;
				phase_q <= fcp_pkg::PH_SKIP;
				fv_q    <= '0;
			end else begin
				if (col_q < fcp_pkg::COL_W'(fcp_pkg::COLUMN_LIMIT))
					col_q <= col_q + fcp_pkg::COL_W'(1);
				kind_q <= kind_n;
				fv_q   <= fv_n;
				if (in_field) begin
					acc_q   <= acc_n;
					neg_q   <= neg_n;
					phase_q <= ph_n;
				end
			end
		end
	end

	a_line_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && beat.line_end) |=> (col_q == '0 && phase_q == fcp_pkg::PH_SKIP &&
		                            fv_q == '0))
		else $error("line state not cleared after line end");

	a_col_limit: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= fcp_pkg::COL_W'(fcp_pkg::COLUMN_LIMIT))
		else $error("column past limit");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !beat.line_end && col_q < fcp_pkg::COL_W'(fcp_pkg::COLUMN_LIMIT))
		|=> col_q == $past(col_q) + fcp_pkg::COL_W'(1))
		else $error("column did not advance");

endmodule

FILE: rtl/fcp_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcp_result
// Type-name decode and result register. Loads one card result when the
// scanner finishes a line; holds it until the downstream side takes it.
// ----------------------------------------------------------------------------
module fcp_result (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  fcp_pkg::line_t      fin,
	input  logic                card_stall,
	output logic                card_valid,
	output fcp_pkg::card_beat_t card_beat,
	output logic                free
);

	logic                valid_q;
	fcp_pkg::card_beat_t beat_q;
	fcp_pkg::card_beat_t beat_d;
	fcp_pkg::kind_dec_t  dec;

	always_comb begin
		dec = fcp_pkg::decode_kind(fin.kind_chars);
		if (dec.ok) begin
			beat_d.status    = fcp_pkg::ST_OK;
			beat_d.elem_kind = dec.kind;
			beat_d.elem_id   = fin.fields[0];
			beat_d.node_a    = fin.fields[1];
			beat_d.node_b    = fin.fields[2];
			beat_d.node_c    = (dec.kind == fcp_pkg::KIND_BEAM) ? '1 : fin.fields[3];
			beat_d.node_d    = (dec.kind == fcp_pkg::KIND_QUAD) ? fin.fields[4] : '1;
		end else begin
			beat_d.status    = fcp_pkg::ST_UNKNOWN;
			beat_d.elem_kind = fcp_pkg::KIND_TRI;
			beat_d.elem_id   = '1;
			beat_d.node_a    = '0;
			beat_d.node_b    = '0;
			beat_d.node_c    = '0;
			beat_d.node_d    = '0;
		end
	end

	assign free       = !valid_q || !card_stall;
	assign card_valid = valid_q;
	assign card_beat  = beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!card_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			beat_q <= beat_d;
	end

endmodule

FILE: rtl/fixed_column_element_card_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_column_element_card_parser_core
// Streams a card line one character per beat and returns the decoded
// element type, id and node ids once the line's last char has been folded in.
//
//   channel  dir  handshake              payload
//   char     in   char_valid/char_stall  char_beat (char_code, line_end)
//   card     out  card_valid/card_stall  card_beat (status .. node_d)
//
// One character per cycle sustained while no line end waits; a character
// beat is registered, then folded into the line state (compare, x10 add,
// negate). The output register loads a line's result as its line-ending
// beat is folded in. Only a line-ending beat waits on a full, stalled
// output register; mid-line characters never stall.
// Reset clears the line state to an empty line (blank type, zero fields).
// ----------------------------------------------------------------------------
module fixed_column_element_card_parser_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_stall,
	input  fcp_pkg::char_beat_t char_beat,
	output logic                card_valid,
	input  logic                card_stall,
	output fcp_pkg::card_beat_t card_beat
);

	logic                valid_s1;
	fcp_pkg::char_beat_t beat_s1;
	logic                adv;
	logic                out_free;
	fcp_pkg::line_t      fin;

	assign adv        = valid_s1 && (!beat_s1.line_end || out_free);
	assign char_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!char_stall && char_valid)
			beat_s1 <= char_beat;
	end

	fcp_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.beat   (beat_s1),
		.fin    (fin)
	);

	fcp_result u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv && beat_s1.line_end),
		.fin        (fin),
		.card_stall (card_stall),
		.card_valid (card_valid),
		.card_beat  (card_beat),
		.free       (out_free)
	);

	a_end_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && beat_s1.line_end && card_valid && card_stall) |-> char_stall)
		else $error("line end overran a held result");

	a_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && beat_s1.line_end) |=> card_valid)
		else $error("line end produced no result");

	a_mid_flows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !beat_s1.line_end) |-> !char_stall)
		else $error("mid-line character stalled");

endmodule

FILE: sim/fixed_column_element_card_parser_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_column_element_card_parser_core_test
// Streams card lines into the parser one character beat at a time and
// checks each decoded card against a line scanner kept in the testbench.
// Directed lines cover the three element names, padding and unknown names,
// short, long and sign-only fields. Random lines follow, mostly well-formed
// cards with random fields, some noise. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module fixed_column_element_card_parser_core_test;

	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 20;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                char_valid = 1'b0;
	logic                char_stall;
	fcp_pkg::char_beat_t char_beat = '0;
	logic                card_valid;
	logic                card_stall = 1'b0;
	fcp_pkg::card_beat_t card_beat;

	fixed_column_element_card_parser_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat),
		.card_valid (card_valid),
		.card_stall (card_stall),
		.card_beat  (card_beat)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// line scanner: mirrors what the parser should decode
	// ------------------------------------------------------------------
	int unsigned          scan_col;
	logic [7:0]           name_buf [6];
	logic [26:0]          num_mag;
	bit                   num_neg;
	fcp_pkg::phase_t      num_phase;
	logic [27:0]          field_val [5];
	fcp_pkg::card_beat_t  expected_cards[$];

	fcp_pkg::char_beat_t  pending_chars[$];
	logic [7:0]           line_buf[$];
	bit                   char_taken = 1'b0;
	int                   mismatches = 0;
	int                   cycle_count = 0;
	int                   sent_chars = 0;
	int                   sent_lines = 0;
	bit                   hold_request = 1'b0;

	function automatic bit is_blank(logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic void clear_line();
		scan_col = 0;
		foreach (name_buf[i]) name_buf[i] = fcp_pkg::CH_SPACE;
		num_mag = '0;
		num_neg = 1'b0;
		num_phase = fcp_pkg::PH_SKIP;
		foreach (field_val[i]) field_val[i] = '0;
	endfunction

	// trimmed type text name_buf[lo..hi) against a name of n chars
	function automatic bit name_is(logic [5:0][7:0] want_name, int n, int lo, int hi);
		if (hi - lo != n) return 1'b0;
		for (int i = 0; i < n; i++)
			if (name_buf[lo + i] != want_name[i]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic void absorb_char(fcp_pkg::char_beat_t b);
		int                  slot;
		int                  lo;
		int                  hi;
		bit                  took_sign;
		bit                  known;
		fcp_pkg::kind_t      kind;
		logic [27:0]         mag;
		fcp_pkg::card_beat_t card;
		slot = -1;
		took_sign = 1'b0;
		if (scan_col < 6) name_buf[scan_col] = b.char_code;
		if (scan_col >= 8 && scan_col <= 15) slot = 0;
		else if (scan_col >= 24 && scan_col <= 55) slot = 1 + (scan_col - 24) / 8;
		if (slot >= 0) begin
			if (scan_col % 8 == 0) begin
				num_mag = '0;
				num_neg = 1'b0;
				num_phase = fcp_pkg::PH_SKIP;
			end
			if (num_phase == fcp_pkg::PH_SKIP && !is_blank(b.char_code)) begin
				num_phase = fcp_pkg::PH_NUM;
				if (b.char_code == fcp_pkg::CH_MINUS) begin
					num_neg = 1'b1;
					took_sign = 1'b1;
				end else if (b.char_code == fcp_pkg::CH_PLUS) begin
					took_sign = 1'b1;
				end
			end
			if (num_phase == fcp_pkg::PH_NUM && !took_sign) begin
				if (b.char_code >= fcp_pkg::CH_ZERO && b.char_code <= fcp_pkg::CH_NINE)
					num_mag = num_mag * 27'd10 + 27'(b.char_code - fcp_pkg::CH_ZERO);
				else
					num_phase = fcp_pkg::PH_STOP;
			end
			if (scan_col % 8 == 7 || b.line_end) begin
				mag = {1'b0, num_mag};
				field_val[slot] = num_neg ? -mag : mag;
			end
		end
		if (scan_col < fcp_pkg::COLUMN_LIMIT) scan_col++;
		if (!b.line_end) return;

		lo = 0;
		while (lo < 6 && is_blank(name_buf[lo])) lo++;
		hi = 6;
		while (hi > lo && is_blank(name_buf[hi - 1])) hi--;
		known = 1'b1;
		kind = fcp_pkg::KIND_TRI;
		if (name_is(fcp_pkg::NAME_TRI, 6, lo, hi)) kind = fcp_pkg::KIND_TRI;
		else if (name_is(fcp_pkg::NAME_QUAD, 6, lo, hi)) kind = fcp_pkg::KIND_QUAD;
		else if (name_is({8'h00, fcp_pkg::NAME_BEAM}, 5, lo, hi)) kind = fcp_pkg::KIND_BEAM;
		else known = 1'b0;

		if (!known) begin
			card.status = fcp_pkg::ST_UNKNOWN;
			card.elem_kind = fcp_pkg::KIND_TRI;
			card.elem_id = '1;
			card.node_a = '0;
			card.node_b = '0;
			card.node_c = '0;
			card.node_d = '0;
		end else begin
			card.status = fcp_pkg::ST_OK;
			card.elem_kind = kind;
			card.elem_id = field_val[0];
			card.node_a = field_val[1];
			card.node_b = field_val[2];
			card.node_c = (kind == fcp_pkg::KIND_BEAM) ? '1 : field_val[3];
			card.node_d = (kind == fcp_pkg::KIND_QUAD) ? field_val[4] : '1;
		end
		expected_cards.push_back(card);
		clear_line();
	endfunction

	function automatic void check_field(string what, logic signed [27:0] want,
	                                    logic signed [27:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// ------------------------------------------------------------------
	// monitor: both channels sampled at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		fcp_pkg::card_beat_t want;
		if (arst_n) begin
			char_taken = char_valid && !char_stall;
			if (char_taken) absorb_char(char_beat);
			if (card_valid && !card_stall) begin
				if (expected_cards.size() == 0) begin
					$display("%0t: card beat with none expected, expected nothing, got id %0d",
					         $time, card_beat.elem_id);
					mismatches++;
				end else begin
					want = expected_cards.pop_front();
					check_field("status", 28'(want.status), 28'(card_beat.status));
					check_field("elem_kind", 28'(want.elem_kind), 28'(card_beat.elem_kind));
					check_field("elem_id", want.elem_id, card_beat.elem_id);
					check_field("node_a", want.node_a, card_beat.node_a);
					check_field("node_b", want.node_b, card_beat.node_b);
					check_field("node_c", want.node_c, card_beat.node_c);
					check_field("node_d", want.node_d, card_beat.node_d);
				end
			end
		end
	end

	// mostly no gap, some short ones, a few long
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------
	// character driver
	// ------------------------------------------------------------------
	int send_gap = 0;
	int send_quiet = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
		end else if (!char_valid || char_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				char_valid <= 1'b0;
			end else if (pending_chars.size() > 0) begin
				char_beat <= pending_chars.pop_front();
				char_valid <= 1'b1;
				if (send_quiet > 0) begin
					send_quiet--;
				end else if ($urandom_range(0, 99) < 2) begin
					send_quiet = $urandom_range(40, 150);
				end else begin
					send_gap = draw_gap();
				end
			end else begin
				char_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// card receiver stall
	// ------------------------------------------------------------------
	int hold_left = 0;
	int stall_left = 0;
	int stall_quiet = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			card_stall <= 1'b0;
		end else begin
			if (hold_request && hold_left == 0) begin
				hold_left = 400;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				card_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				card_stall <= 1'b1;
			end else if (stall_quiet > 0) begin
				stall_quiet--;
				card_stall <= 1'b0;
			end else begin
				if ($urandom_range(0, 99) < 2)
					stall_quiet = $urandom_range(40, 150);
				else
					stall_left = draw_gap();
				card_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// line building
	// ------------------------------------------------------------------
	task automatic put_byte(logic [7:0] c);
		line_buf.push_back(c);
	endtask

	task automatic put_str(string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endtask

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 7))
			0: return 8'h09;
			1: return 8'h0A;
			2: return 8'h0B;
			3: return 8'h0C;
			4: return 8'h0D;
			default: return fcp_pkg::CH_SPACE;
		endcase
	endfunction

	function automatic logic [7:0] pad_char();
		return ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : fcp_pkg::CH_SPACE;
	endfunction

	task automatic send_line();
		fcp_pkg::char_beat_t b;
		foreach (line_buf[i]) begin
			b.char_code = line_buf[i];
			b.line_end = (i == line_buf.size() - 1);
			pending_chars.push_back(b);
		end
		sent_chars += line_buf.size();
		sent_lines++;
		line_buf.delete();
	endtask

	task automatic put_kind_name();
		case ($urandom_range(0, 11))
			0, 1, 2: put_str("CTRIA3");
			3, 4, 5: put_str("CQUAD4");
			6: begin
				put_str("CBEAM");
				put_byte(blank_char());
			end
			7: begin
				put_byte(blank_char());
				put_str("CBEAM");
			end
			8: begin
				put_str(($urandom_range(0, 1) == 0) ? "CQUAD4" : "CTRIA3");
				line_buf[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
			end
			9: repeat (6) put_byte(8'($urandom_range(0, 255)));
			10: begin
				put_str("CBEAM");
				put_byte(8'($urandom_range(0, 255)));
			end
			default: begin
				put_str("CTRIA");
				put_byte(blank_char());
			end
		endcase
	endtask

	task automatic put_number_field();
		logic [7:0] field_chars[$];
		int         digits;
		repeat (($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(0, 8))
			field_chars.push_back(blank_char());
		case ($urandom_range(0, 5))
			0: field_chars.push_back(fcp_pkg::CH_MINUS);
			1: field_chars.push_back(fcp_pkg::CH_PLUS);
			default: ;
		endcase
		digits = $urandom_range(0, 8);
		repeat (digits) field_chars.push_back(fcp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
		if ($urandom_range(0, 4) == 0) field_chars.push_back(8'($urandom_range(0, 255)));
		while (field_chars.size() < 8) field_chars.push_back(pad_char());
		for (int i = 0; i < 8; i++) put_byte(field_chars[i]);
	endtask

	task automatic random_card();
		int keep;
		if ($urandom_range(0, 9) < 8) begin
			put_kind_name();
			repeat (2) put_byte(pad_char());
			put_number_field();
			repeat (8) put_byte(pad_char());
			repeat (4) put_number_field();
			if ($urandom_range(0, 19) == 0)
				repeat ($urandom_range(60, 150)) put_byte(8'($urandom_range(0, 255)));
			else if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 10)) put_byte(pad_char());
		end else begin
			repeat ($urandom_range(1, 80)) put_byte(8'($urandom_range(0, 255)));
		end
		// cut short about half the lines, anywhere down to one character
		if ($urandom_range(0, 1) == 0) begin
			keep = $urandom_range(1, line_buf.size());
			while (line_buf.size() > keep) void'(line_buf.pop_back());
		end
		send_line();
	endtask

	task automatic wait_idle();
		while (pending_chars.size() != 0 || char_valid) @(posedge clk);
		while (expected_cards.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		clear_line();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		put_str("CTRIA3         1               2       3       4");
		send_line();
		put_str("CQUAD4  99999999        -9999999+1234567   00042      -0");
		send_line();
		put_str("CBEAM     +17   xxxxxxxx12ab34   - 5           9       8");
		send_line();
		put_str(" CBEAM  ");
		put_byte(8'h0B);
		put_byte(8'h0C);
		put_byte(8'h0D);
		put_byte(8'h0A);
		put_str("  -3");
		send_line();
		put_byte(8'h09);
		put_str("CBEAM  7");
		send_line();
		put_str("CBAR    12345678        1       2");
		send_line();
		put_str("CTRIA3  12");
		send_line();
		put_str("C");
		send_line();
		put_str("      ");
		send_line();
		put_str("CQUAD4  5               77");
		send_line();
		// sign-only and empty fields
		put_str("CTRIA3  -       ........+       -               +");
		send_line();
		// past the last field and past the column limit
		put_str("CQUAD4  42      abcdefgh");
		repeat (180) put_byte(8'h39);
		send_line();
		put_str("CTRIA3");
		put_byte(8'hFF);
		put_byte(8'h00);
		put_byte(8'h80);
		put_str("9");
		send_line();
		// lines ending on the last column of the node area and just after
		put_str("CQUAD4         1       2       3       4       5       6");
		send_line();
		put_str("CQUAD4         1       2       3       4       5       6x");
		send_line();
		wait_idle();

		// receiver holds off while the lines keep coming
		repeat (20) random_card();
		hold_request = 1'b1;
		while (sent_chars < 700) random_card();
		wait_idle();

		while (sent_chars < 1400 || sent_lines < 60) random_card();
		wait_idle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
rtl/fcp_pkg.sv
rtl/fcp_scan.sv
rtl/fcp_result.sv
rtl/fixed_column_element_card_parser_core.sv
sim/fixed_column_element_card_parser_core_test.sv
